@@ rtl/core/sms_pkg.sv @@
// Shared types and constants for the SPI master shifter.
package sms_pkg;

  // Queue depth between the front and the engine
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register map (register index = paddr[3:2])
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] REG_CLOCK_POLARITY = 2'd0;
  localparam logic [1:0] REG_CLOCK_PHASE    = 2'd1;
  localparam logic [1:0] REG_SELECT_PULSE   = 2'd2;

  // Input op codes
  localparam logic OP_QUEUE_BYTE = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  // Input beat
  typedef struct packed {
    logic       op;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       miso;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic       accepted;
    logic       sck;
    logic       mosi;
    logic       cs_n;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       block_done;
  } out_item_t;

  // Classified command kind
  typedef enum logic {
    CMD_LOAD,
    CMD_TICK
  } cmd_kind_t;

  // Queue entry between front and engine
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       miso;
  } cmd_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic polarity;
    logic phase;
    logic pulse_between;
    logic polarity_wr;
    logic polarity_wdata;
  } cfg_t;

endpackage

@@ rtl/core/sms_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the engine.
module sms_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sms_pkg::in_item_t in_data,
  output logic             head_valid,
  output sms_pkg::cmd_t    head,
  input  logic             pop
);

  sms_pkg::cmd_t                      entries [sms_pkg::QueueDepth];
  logic [sms_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [sms_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [sms_pkg::QueueCntW-1:0]      count;
  logic                               push;
  logic                               pop_ok;
  sms_pkg::cmd_t                      cmd_in;

  // Classify the incoming beat
  always_comb begin
    cmd_in.kind = (in_data.op == sms_pkg::OP_TICK) ? sms_pkg::CMD_TICK : sms_pkg::CMD_LOAD;
    cmd_in.data = in_data.tx_byte;
    cmd_in.last = in_data.last_byte;
    cmd_in.miso = in_data.miso;
  end

  assign in_ready   = (count != sms_pkg::QueueCntW'(sms_pkg::QueueDepth));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign pop_ok     = pop && head_valid;
  assign head       = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sms_pkg::QueuePtrW'(sms_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == sms_pkg::QueuePtrW'(sms_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/sms_back.sv @@
// Back end: shift engine, holding register, pin levels and output register.
module sms_back (
  input  logic              clk,
  input  logic              rst,
  input  sms_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  sms_pkg::cmd_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output sms_pkg::out_item_t out_data
);

  // Engine state
  logic [7:0] shift_reg, shift_reg_next;
  logic [2:0] bit_index, bit_index_next;
  logic       half_phase, half_phase_next;
  logic       busy, busy_next;
  logic       current_is_last, current_is_last_next;
  logic [7:0] hold_byte, hold_byte_next;
  logic       hold_valid, hold_valid_next;
  logic       hold_last, hold_last_next;
  logic       sck_level, sck_level_next;
  logic       select_level, select_level_next;
  logic       mosi_level, mosi_level_next;

  sms_pkg::out_item_t res;
  logic               step;
  logic [2:0]         bit_below;

  assign pop       = !out_valid || out_ready;
  assign step      = pop && head_valid;
  assign bit_below = bit_index - 3'd1;

  // Next state and result for the command at the queue head
  always_comb begin
    shift_reg_next       = shift_reg;
    bit_index_next       = bit_index;
    half_phase_next      = half_phase;
    busy_next            = busy;
    current_is_last_next = current_is_last;
    hold_byte_next       = hold_byte;
    hold_valid_next      = hold_valid;
    hold_last_next       = hold_last;
    sck_level_next       = sck_level;
    select_level_next    = select_level;
    mosi_level_next      = mosi_level;
    res                  = '0;

    if (step) begin
      unique case (head.kind)
        sms_pkg::CMD_LOAD: begin
          if (!hold_valid) begin
            hold_byte_next  = head.data;
            hold_last_next  = head.last;
            hold_valid_next = 1'b1;
            res.accepted    = 1'b1;
          end
        end
        sms_pkg::CMD_TICK: begin
          if (!busy) begin
            // start tick: load the held byte and assert select
            if (hold_valid) begin
              shift_reg_next       = hold_byte;
              current_is_last_next = hold_last;
              hold_valid_next      = 1'b0;
              busy_next            = 1'b1;
              bit_index_next       = 3'd7;
              half_phase_next      = 1'b0;
              select_level_next    = 1'b0;
              sck_level_next       = cfg.polarity;
              mosi_level_next      = hold_byte[7];
            end
          end else if (!half_phase) begin
            // leading edge
            sck_level_next = !cfg.polarity;
            if (cfg.phase) begin
              mosi_level_next = shift_reg[bit_index];
            end else begin
              shift_reg_next[bit_index] = head.miso;
            end
            half_phase_next = 1'b1;
          end else begin
            // trailing edge
            sck_level_next = cfg.polarity;
            if (cfg.phase) begin
              shift_reg_next[bit_index] = head.miso;
            end else if (bit_index != 3'd0) begin
              mosi_level_next = shift_reg[bit_below];
            end
            half_phase_next = 1'b0;
            if (bit_index == 3'd0) begin
              res.rx_valid   = 1'b1;
              res.rx_byte    = shift_reg_next;
              busy_next      = 1'b0;
              bit_index_next = 3'd7;
              if (current_is_last) begin
                select_level_next = 1'b1;
                res.block_done    = 1'b1;
              end else if (cfg.pulse_between) begin
                select_level_next = 1'b1;
              end
            end else begin
              bit_index_next = bit_below;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // polarity write while idle moves SCK to the new idle level
    if (cfg.polarity_wr && !busy) begin
      sck_level_next = cfg.polarity_wdata;
    end

    res.sck  = sck_level_next;
    res.mosi = mosi_level_next;
    res.cs_n = select_level_next;
  end

  // Payload state without reset
  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    if (step) begin
      out_data <= res;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg       <= '0;
      bit_index       <= 3'd7;
      half_phase      <= 1'b0;
      busy            <= 1'b0;
      current_is_last <= 1'b0;
      hold_valid      <= 1'b0;
      hold_last       <= 1'b0;
      sck_level       <= 1'b1;
      select_level    <= 1'b1;
      mosi_level      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      shift_reg       <= shift_reg_next;
      bit_index       <= bit_index_next;
      half_phase      <= half_phase_next;
      busy            <= busy_next;
      current_is_last <= current_is_last_next;
      hold_valid      <= hold_valid_next;
      hold_last       <= hold_last_next;
      sck_level       <= sck_level_next;
      select_level    <= select_level_next;
      mosi_level      <= mosi_level_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/spi_master_shifter_unit.sv @@
// SPI master shifter top level: config registers, front queue and shift engine.
//
// Input channel (in_valid/in_ready/in_data): each beat is either a byte to
// queue into the one-byte holding register or a half-bit tick carrying the
// sampled MISO level. Output channel (out_valid/out_ready/out_data): exactly
// one beat per input beat, in order, with the pin levels (SCK, MOSI, CS_N)
// after that item, the accepted flag, a received byte and block_done.
// Path: an accepted beat is written into the queue and, once popped, into the
// output register. Throughput: one beat per cycle unless the output stalls;
// the engine advances one tick per clock through its next-state logic.
// A two-entry queue sits between input and engine, so in_ready stays high
// while the output is stalled until that queue fills; the engine holds its
// result in the output register while out_ready is low.
// Reset (rst, synchronous): queue empty, output empty, SCK high (polarity
// reset 1, phase 1, no select pulsing), CS_N high, MOSI low, nothing held.
// Config over APB at 0x0 polarity, 0x4 phase, 0x8 select pulsing; write only
// while idle.
module spi_master_shifter_unit (
  input  logic                        clk,
  input  logic                        rst,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sms_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sms_pkg::in_item_t           in_data,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output sms_pkg::out_item_t          out_data
);

  logic          clock_polarity;
  logic          clock_phase;
  logic          select_pulse_between;
  logic          wr_en;
  logic [1:0]    reg_idx;
  sms_pkg::cfg_t cfg;
  logic          head_valid;
  sms_pkg::cmd_t head;
  logic          pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_polarity       <= 1'b1;
      clock_phase          <= 1'b1;
      select_pulse_between <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sms_pkg::REG_CLOCK_POLARITY: clock_polarity       <= pwdata[0];
        sms_pkg::REG_CLOCK_PHASE:    clock_phase          <= pwdata[0];
        sms_pkg::REG_SELECT_PULSE:   select_pulse_between <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      sms_pkg::REG_CLOCK_POLARITY: prdata = {31'd0, clock_polarity};
      sms_pkg::REG_CLOCK_PHASE:    prdata = {31'd0, clock_phase};
      sms_pkg::REG_SELECT_PULSE:   prdata = {31'd0, select_pulse_between};
      default:                     prdata = '0;
    endcase
  end

  // Config bundle for the engine
  always_comb begin
    cfg.polarity       = clock_polarity;
    cfg.phase          = clock_phase;
    cfg.pulse_between  = select_pulse_between;
    cfg.polarity_wr    = wr_en && (reg_idx == sms_pkg::REG_CLOCK_POLARITY);
    cfg.polarity_wdata = pwdata[0];
  end

  sms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // block_done always comes with select released and a received byte
  a_done_releases_cs: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.block_done |-> out_data.cs_n && out_data.rx_valid)
    else $error("block_done without CS release or received byte");

  // a queued byte and a received byte never share one beat
  a_accept_rx_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.accepted && out_data.rx_valid))
    else $error("accepted and rx_valid in the same beat");

  // output is empty right after reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
